### hw/rtl/dfr_pkg.sv
package dfr_pkg;

	localparam int LANE_W  = 16;
	localparam int LANES   = 4;
	localparam int FACE_W  = LANE_W * LANES;
	localparam int CNT_W   = 11;
	localparam int FS_W    = 3;
	localparam int CMD_W   = 2;
	localparam int STAT_W  = 2;
	localparam int SLOT_W  = 10;
	localparam int IN_DW   = 80;
	localparam int OUT_DW  = 88;

	localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_COMPACT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic            start;
		logic [FS_W-1:0] size;
	} canon_req_t;

endpackage

### hw/rtl/dfr_cell.sv
module dfr_cell import dfr_pkg::*; (
	input  logic              clk,
	input  logic              load,
	input  logic [LANE_W-1:0] load_val,
	input  logic              shift,
	input  logic [LANE_W-1:0] nb_val,
	output logic [LANE_W-1:0] val
);

	logic [LANE_W-1:0] val_q;

	always_ff @(posedge clk) begin
		if (load) begin
			val_q <= load_val;
		end else if (shift) begin
			val_q <= nb_val;
		end
	end

	assign val = val_q;

endmodule

### hw/rtl/dfr_canon.sv
module dfr_canon import dfr_pkg::*; #(
	parameter int MAX_FACE_SIZE = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  canon_req_t        req,
	input  logic [FACE_W-1:0] face,
	output logic              done,
	output logic [FACE_W-1:0] canon
);

	logic [LANE_W-1:0] val  [MAX_FACE_SIZE];
	logic [LANE_W-1:0] nb   [MAX_FACE_SIZE];
	logic [FACE_W-1:0] snap;
	logic              busy_q;
	logic              done_q;
	logic [FS_W-1:0]   step_q;
	logic [FS_W-1:0]   size_q;
	logic [LANE_W-1:0] best_q;
	logic [FACE_W-1:0] canon_q;

	for (genvar i = 0; i < MAX_FACE_SIZE; i++) begin : g_cell
		if (i == MAX_FACE_SIZE - 1) begin : g_last
			assign nb[i] = (FS_W'(i) == size_q - 3'd1) ? val[0] : '0;
		end else begin : g_mid
			assign nb[i] = (FS_W'(i) == size_q - 3'd1) ? val[0] :
				(FS_W'(i) < size_q - 3'd1) ? val[i+1] : '0;
		end
		dfr_cell u_cell (
			.clk      (clk),
			.load     (req.start),
			.load_val (face[i*LANE_W +: LANE_W]),
			.shift    (busy_q),
			.nb_val   (nb[i]),
			.val      (val[i])
		);
	end

	for (genvar l = 0; l < LANES; l++) begin : g_snap
		if (l < MAX_FACE_SIZE) begin : g_on
			assign snap[l*LANE_W +: LANE_W] = val[l];
		end else begin : g_off
			assign snap[l*LANE_W +: LANE_W] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == size_q - 3'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			size_q <= req.size;
		end
		if (busy_q && (step_q == '0 || val[0] < best_q)) begin
			best_q  <= val[0];
			canon_q <= snap;
		end
	end

	assign done  = done_q;
	assign canon = canon_q;

endmodule

### hw/rtl/duplicate_face_removal.sv
// Duplicate face removal over a store of up to MAX_FACES faces.
// Requests arrive on the s_ channel: s_tuser carries the command (load, compact,
// read, clear), s_tdata the four vertex indices and the read slot. Every request
// gives exactly one response on the m_ channel: m_tuser carries the status,
// m_tdata the duplicate flag, kept and removed counts and the face read back.
// The cfg channel writes the face size (3 or 4); write it only while idle.
// One request is in work at a time; s_tready is high in the idle state only.
// Steps from request to response, with F faces held and n vertices per face:
//   load      rotation ring of n cells, then one stored
//             canonical face compared per cycle through the memory read port
//   compact   per slot from the top down: a mark read (S_CRD), then a slot move if marked (S_CWR)
//   read      S_RD, S_RDW, then S_RESP; clear and rejected requests go straight to S_RESP.
// The response sits in an output register; a new request is taken while it
// waits, and a finished request holds until the receiver takes the previous one.
// Reset empties the store, zeroes the removed count and sets the face size to 3.
// No clearing pass runs after reset.
module duplicate_face_removal import dfr_pkg::*; #(
	parameter int MAX_FACES     = 1024,
	parameter int INDEX_BITS    = 16,
	parameter int MAX_FACE_SIZE = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_DW-1:0]  s_tdata,  // vert_a, vert_b, vert_c, vert_d, slot, zero pad
	input  logic [CMD_W-1:0]  s_tuser,  // cmd
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_DW-1:0] m_tdata,  // duplicate, kept_count, removed_count,
	                                    // out_a, out_b, out_c, out_d, zero pad
	output logic [STAT_W-1:0] m_tuser,  // status
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [FS_W-1:0]   cfg_data  // face_size
);

	localparam int AW = $clog2(MAX_FACES);
	localparam int CW = $clog2(MAX_FACES + 1);
	localparam logic [LANE_W-1:0] IMASK = LANE_W'((32'd1 << INDEX_BITS) - 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CANON = 4'd1;
	localparam logic [3:0] S_SCAN  = 4'd2;
	localparam logic [3:0] S_WRITE = 4'd3;
	localparam logic [3:0] S_CRD   = 4'd4;
	localparam logic [3:0] S_CWR   = 4'd5;
	localparam logic [3:0] S_RD    = 4'd6;
	localparam logic [3:0] S_RDW   = 4'd7;
	localparam logic [3:0] S_RESP  = 4'd8;

	logic [3:0]        st_q;
	logic [FS_W-1:0]   face_size_q;
	logic [FS_W-1:0]   n_act;
	logic [CW-1:0]     ft_q;
	logic [CW-1:0]     removed_q;
	logic [CW-1:0]     k_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     cnt_nx;
	logic [AW-1:0]     m_q;
	logic [AW-1:0]     tail_q;
	logic [AW-1:0]     slot_q;
	logic              hit_q;
	logic              cmp_vld_s1;
	logic [FACE_W-1:0] face_q;
	logic [FACE_W-1:0] face_in;
	logic [31:0]       slot32;
	logic              accept;

	logic [STAT_W-1:0] res_status_q;
	logic              res_dup_q;
	logic [FACE_W-1:0] res_face_q;

	logic              mv_q;
	logic [STAT_W-1:0] o_status_q;
	logic              o_dup_q;
	logic [CNT_W-1:0]  o_kept_q;
	logic [CNT_W-1:0]  o_rem_q;
	logic [FACE_W-1:0] o_face_q;

	canon_req_t        creq;
	logic              canon_done;
	logic [FACE_W-1:0] canon_val;

	logic [FACE_W-1:0] face_mem  [MAX_FACES];
	logic [FACE_W-1:0] canon_mem [MAX_FACES];
	logic              mark_mem  [MAX_FACES];
	logic [FACE_W-1:0] face_rd_q;
	logic [FACE_W-1:0] canon_rd_q;
	logic              mark_rd_q;
	logic              face_we;
	logic              canon_we;
	logic              mark_we;
	logic [AW-1:0]     waddr;
	logic [FACE_W-1:0] face_wdata;
	logic [FACE_W-1:0] canon_wdata;
	logic              mark_wdata;
	logic [AW-1:0]     face_raddr;
	logic [AW-1:0]     canon_raddr;

	assign s_tready  = (st_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign slot32    = 32'(s_tdata[64 +: SLOT_W]);

	always_comb begin
		if (face_size_q < 3'd3) begin
			n_act = 3'd3;
		end else if (face_size_q > FS_W'(MAX_FACE_SIZE)) begin
			n_act = FS_W'(MAX_FACE_SIZE);
		end else begin
			n_act = face_size_q;
		end
		for (int l = 0; l < LANES; l++) begin
			face_in[l*LANE_W +: LANE_W] = (FS_W'(l) < n_act) ?
				(s_tdata[l*LANE_W +: LANE_W] & IMASK) : '0;
		end
	end

	assign creq.start = accept && (s_tuser == CMD_LOAD) && (ft_q != CW'(MAX_FACES));
	assign creq.size  = n_act;

	dfr_canon #(
		.MAX_FACE_SIZE (MAX_FACE_SIZE)
	) u_canon (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.face   (face_in),
		.done   (canon_done),
		.canon  (canon_val)
	);

	assign cnt_nx = cnt_q + CW'(mark_rd_q);

	always_comb begin
		waddr       = (st_q == S_WRITE) ? ft_q[AW-1:0] : m_q;
		face_we     = (st_q == S_WRITE) || (st_q == S_CWR && mark_rd_q);
		canon_we    = face_we;
		mark_we     = (st_q == S_WRITE) || (st_q == S_CWR);
		face_wdata  = (st_q == S_WRITE) ? face_q : face_rd_q;
		canon_wdata = (st_q == S_WRITE) ? canon_val : canon_rd_q;
		mark_wdata  = (st_q == S_WRITE) ? hit_q : 1'b0;
		face_raddr  = (st_q == S_CRD) ? tail_q : slot_q;
		canon_raddr = (st_q == S_CRD) ? tail_q : k_q[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (face_we) begin
			face_mem[waddr] <= face_wdata;
		end
		face_rd_q <= face_mem[face_raddr];
	end

	always_ff @(posedge clk) begin
		if (canon_we) begin
			canon_mem[waddr] <= canon_wdata;
		end
		canon_rd_q <= canon_mem[canon_raddr];
	end

	always_ff @(posedge clk) begin
		if (mark_we) begin
			mark_mem[waddr] <= mark_wdata;
		end
		mark_rd_q <= mark_mem[m_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			face_size_q <= 3'd3;
			ft_q        <= '0;
			removed_q   <= '0;
			k_q         <= '0;
			cnt_q       <= '0;
			hit_q       <= 1'b0;
			cmp_vld_s1  <= 1'b0;
			mv_q        <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				face_size_q <= cfg_data;
			end
			cmp_vld_s1 <= 1'b0;
			if (cmp_vld_s1 && canon_rd_q == canon_val) begin
				hit_q <= 1'b1;
			end
			if (st_q == S_RESP && (!mv_q || m_tready)) begin
				mv_q <= 1'b1;
			end else if (m_tready) begin
				mv_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (accept) begin
						case (s_tuser)
							CMD_LOAD: begin
								if (ft_q == CW'(MAX_FACES)) begin
									st_q <= S_RESP;
								end else begin
									st_q <= S_CANON;
								end
							end
							CMD_COMPACT: begin
								cnt_q <= '0;
								if (ft_q == '0) begin
									removed_q <= '0;
									st_q      <= S_RESP;
								end else begin
									st_q <= S_CRD;
								end
							end
							CMD_READ: begin
								if (slot32 < 32'(ft_q)) begin
									st_q <= S_RD;
								end else begin
									st_q <= S_RESP;
								end
							end
							default: begin
								ft_q      <= '0;
								removed_q <= '0;
								st_q      <= S_RESP;
							end
						endcase
					end
				end
				S_CANON: begin
					if (canon_done) begin
						k_q   <= '0;
						hit_q <= 1'b0;
						st_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (k_q < ft_q) begin
						cmp_vld_s1 <= 1'b1;
						k_q        <= k_q + 1'b1;
					end else begin
						st_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					ft_q <= ft_q + 1'b1;
					st_q <= S_RESP;
				end
				S_CRD: begin
					st_q <= S_CWR;
				end
				S_CWR: begin
					cnt_q <= cnt_nx;
					if (m_q == '0) begin
						ft_q      <= ft_q - cnt_nx;
						removed_q <= cnt_nx;
						st_q      <= S_RESP;
					end else begin
						st_q <= S_CRD;
					end
				end
				S_RD: begin
					st_q <= S_RDW;
				end
				S_RDW: begin
					st_q <= S_RESP;
				end
				S_RESP: begin
					if (!mv_q || m_tready) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				if (accept) begin
					face_q       <= face_in;
					slot_q       <= slot32[AW-1:0];
					m_q          <= AW'(ft_q - 1'b1);
					tail_q       <= AW'(ft_q - 1'b1);
					res_dup_q    <= 1'b0;
					res_face_q   <= '0;
					res_status_q <= ST_OK;
					if (s_tuser == CMD_LOAD && ft_q == CW'(MAX_FACES)) begin
						res_status_q <= ST_FULL;
					end else if (s_tuser == CMD_READ && !(slot32 < 32'(ft_q))) begin
						res_status_q <= ST_RANGE;
					end
				end
			end
			S_WRITE: begin
				res_dup_q <= hit_q;
			end
			S_CWR: begin
				if (mark_rd_q && tail_q != '0) begin
					tail_q <= tail_q - 1'b1;
				end
				if (m_q != '0) begin
					m_q <= m_q - 1'b1;
				end
			end
			S_RDW: begin
				res_face_q <= face_rd_q;
			end
			S_RESP: begin
				if (!mv_q || m_tready) begin
					o_status_q <= res_status_q;
					o_dup_q    <= res_dup_q;
					o_kept_q   <= CNT_W'(ft_q);
					o_rem_q    <= CNT_W'(removed_q);
					o_face_q   <= res_face_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = mv_q;
	assign m_tuser  = o_status_q;
	assign m_tdata  = {1'b0, o_face_q, o_rem_q, o_kept_q, o_dup_q};

`ifndef SYNTH
	a_ft_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ft_q <= CW'(MAX_FACES))
		else $error("face count beyond store depth");

	a_tail_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_CWR |-> tail_q >= m_q)
		else $error("compaction tail below walk position");

	a_canon_done: assert property (@(posedge clk) disable iff (!arst_n)
		canon_done |-> st_q == S_CANON)
		else $error("rotation finished outside its wait state");

	a_dup_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && o_dup_q |-> o_status_q == ST_OK)
		else $error("duplicate flag with non-ok status");
`endif

endmodule
